FILE: sv/iird_pkg.sv
`timescale 1ns / 1ps
// Package for the IIR hysteresis debouncer: payload structs, register map
// and filter constants. No dependencies.
package iird_pkg;

  localparam int LevelW = 16;
  localparam int WeightW = 16;
  localparam int AddrW = 3;
  localparam int DataW = 32;

  localparam logic [LevelW-1:0] LevelFull = 16'd65535;
  localparam logic [LevelW-1:0] ThreshHigh = 16'd41426;   // ~ 1 - 1/e
  localparam logic [LevelW-1:0] ThreshLow = 16'd24109;    // ~ 1/e

  localparam logic [WeightW-1:0] WeightReset = 16'd6554;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_STATUS = 1'b1
  } op_t;

  typedef enum logic {
    REG_FILTER_WEIGHT = 1'b0,
    REG_INVERT_INPUT  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    op_t        operation;
    logic       pin_level;
    logic [2:0] clear_mask;
  } in_t;

  typedef struct packed {
    logic              debounced_state;
    logic              rising_seen;
    logic              falling_seen;
    logic              change_seen;
    logic [LevelW-1:0] filter_out;
  } out_t;

endpackage

FILE: sv/iir_hysteresis_debouncer_top.sv
`timescale 1ns / 1ps
// IIR hysteresis debouncer, top level with APB register block.
// Depends on iird_pkg.
//
// Pipeline: input register, then result register. Throughput: one item per
// cycle while the result port is not stalled; the filter level, state and flags
// update in the single cycle an item leaves the input register.
// Reset (rst, synchronous): filter level, state and flags cleared,
// filter_weight = 6554, invert_input = 0, both pipeline stages empty.
module iir_hysteresis_debouncer_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  iird_pkg::in_t             in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output iird_pkg::out_t            out_data,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [iird_pkg::AddrW-1:0] paddr,
  input  logic [iird_pkg::DataW-1:0] pwdata,
  output logic [iird_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import iird_pkg::*;

  // Config registers
  logic [WeightW-1:0] filter_weight;
  logic               invert_input;

  // Filter state
  logic [LevelW-1:0] filter_level, filter_level_next;
  logic              state_bit, state_bit_next;
  logic              rising_flag, rising_flag_next;
  logic              falling_flag, falling_flag_next;
  logic              change_flag, change_flag_next;

  // Input register
  logic s1_valid;
  in_t  s1_data;
  logic s1_adv;

  out_t result_next;

  reg_idx_t wr_idx;
  logic     cfg_wr;

  // Filter datapath
  logic                 lvl;
  logic [LevelW-1:0]    diff;
  logic [2*LevelW-1:0]  prod;
  logic [2*LevelW:0]    prod_rnd;
  logic [LevelW-1:0]    new_level;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign wr_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    prdata = '0;
    unique case (wr_idx)
      REG_FILTER_WEIGHT: prdata[WeightW-1:0] = filter_weight;
      REG_INVERT_INPUT:  prdata[0] = invert_input;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_weight <= WeightReset;
      invert_input  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (wr_idx)
        REG_FILTER_WEIGHT: filter_weight <= pwdata[WeightW-1:0];
        REG_INVERT_INPUT:  invert_input <= pwdata[0];
      endcase
    end
  end

  // Handshake: stage 1 advances whenever the result register is free or drains
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  // One IIR step; downward steps round the magnitude up (floor of a negative)
  always_comb begin
    lvl       = s1_data.pin_level ^ invert_input;
    diff      = lvl ? (LevelFull - filter_level) : filter_level;
    prod      = filter_weight * diff;
    prod_rnd  = {1'b0, prod} + {{(LevelW+1){1'b0}}, LevelFull};
    new_level = lvl ? (filter_level + prod[2*LevelW-1:LevelW])
                    : (filter_level - prod_rnd[2*LevelW-1:LevelW]);
  end

  always_comb begin
    filter_level_next = filter_level;
    state_bit_next    = state_bit;
    rising_flag_next  = rising_flag;
    falling_flag_next = falling_flag;
    change_flag_next  = change_flag;
    result_next.debounced_state = state_bit;
    result_next.rising_seen     = rising_flag;
    result_next.falling_seen    = falling_flag;
    result_next.change_seen     = change_flag;
    result_next.filter_out      = filter_level;
    unique case (s1_data.operation)
      OP_SAMPLE: begin
        filter_level_next = new_level;
        if (new_level > ThreshHigh) begin
          state_bit_next = 1'b1;
          if (!state_bit) begin
            rising_flag_next = 1'b1;
            change_flag_next = 1'b1;
          end
        end else if (new_level < ThreshLow) begin
          state_bit_next = 1'b0;
          if (state_bit) begin
            falling_flag_next = 1'b1;
            change_flag_next  = 1'b1;
          end
        end
        result_next.debounced_state = state_bit_next;
        result_next.rising_seen     = rising_flag_next;
        result_next.falling_seen    = falling_flag_next;
        result_next.change_seen     = change_flag_next;
        result_next.filter_out      = new_level;
      end
      OP_STATUS: begin
        // report before clearing
        if (s1_data.clear_mask[0]) rising_flag_next = 1'b0;
        if (s1_data.clear_mask[1]) falling_flag_next = 1'b0;
        if (s1_data.clear_mask[2]) change_flag_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_level <= '0;
      state_bit    <= 1'b0;
      rising_flag  <= 1'b0;
      falling_flag <= 1'b0;
      change_flag  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (s1_adv) begin
        filter_level <= filter_level_next;
        state_bit    <= state_bit_next;
        rising_flag  <= rising_flag_next;
        falling_flag <= falling_flag_next;
        change_flag  <= change_flag_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (s1_adv) begin
      out_data <= result_next;
    end
  end

  // Hysteresis invariants
  a_high_level: assert property (@(posedge clk) disable iff (rst)
    state_bit |-> filter_level >= ThreshLow)
    else $error("debounced state high with level below low threshold");

  a_low_level: assert property (@(posedge clk) disable iff (rst)
    !state_bit |-> filter_level <= ThreshHigh)
    else $error("debounced state low with level above high threshold");

  a_status_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_data.operation == OP_STATUS) |=>
      (filter_level == $past(filter_level) && state_bit == $past(state_bit)))
    else $error("status read changed filter state");

  a_change_edge: assert property (@(posedge clk) disable iff (rst)
    $rose(change_flag) |-> (rising_flag || falling_flag))
    else $error("change flag set without edge flag");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !s1_adv)
    else $error("pending result overwritten");

endmodule

FILE: bench/iird_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the IIR hysteresis debouncer: snoops the sample, result and
// register ports, predicts every result and compares it. Depends on iird_pkg.
module iird_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  iird_pkg::in_t              in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  iird_pkg::out_t             out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [iird_pkg::AddrW-1:0] paddr,
  input  logic [iird_pkg::DataW-1:0] pwdata,
  output int                         errors,
  output int                         pending,
  output int                         results_seen
);
  import iird_pkg::*;

  logic [WeightW-1:0] weight_q;
  logic               invert_q;
  logic [LevelW-1:0]  level_q;
  logic               state_q;
  logic               rise_q;
  logic               fall_q;
  logic               change_q;
  out_t               expected_results[$];
  int                 err_n = 0;
  int                 res_n = 0;

  function automatic logic [LevelW-1:0] iir_update(logic [LevelW-1:0] lvl,
                                                   logic toward_full,
                                                   logic [WeightW-1:0] w);
    logic [31:0] prod;
    logic [32:0] rounded;
    if (toward_full) begin
      prod = w * (LevelFull - lvl);
      return lvl + prod[31:16];
    end
    prod = w * lvl;
    // floor of a negative step: the magnitude rounds up
    rounded = {1'b0, prod} + 33'd65535;
    return lvl - rounded[31:16];
  endfunction

  task automatic debounce_step(in_t it);
    out_t res;
    if (it.operation == OP_SAMPLE) begin
      level_q = iir_update(level_q, it.pin_level ^ invert_q, weight_q);
      if (level_q > ThreshHigh) begin
        if (!state_q) begin
          rise_q   = 1'b1;
          change_q = 1'b1;
        end
        state_q = 1'b1;
      end else if (level_q < ThreshLow) begin
        if (state_q) begin
          fall_q   = 1'b1;
          change_q = 1'b1;
        end
        state_q = 1'b0;
      end
    end
    res.debounced_state = state_q;
    res.rising_seen     = rise_q;
    res.falling_seen    = fall_q;
    res.change_seen     = change_q;
    res.filter_out      = level_q;
    // status read reports flags as they were, then clears
    if (it.operation == OP_STATUS) begin
      if (it.clear_mask[0]) rise_q = 1'b0;
      if (it.clear_mask[1]) fall_q = 1'b0;
      if (it.clear_mask[2]) change_q = 1'b0;
    end
    expected_results.push_back(res);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_n++;
    end
  endtask

  always @(posedge clk) begin : monitor
    out_t want;
    if (rst) begin
      weight_q = WeightReset;
      invert_q = 1'b0;
      level_q  = '0;
      state_q  = 1'b0;
      rise_q   = 1'b0;
      fall_q   = 1'b0;
      change_q = 1'b0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[AddrW-1:2]))
          REG_FILTER_WEIGHT: weight_q = pwdata[WeightW-1:0];
          REG_INVERT_INPUT:  invert_q = pwdata[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        res_n++;
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected");
          err_n++;
        end else begin
          want = expected_results.pop_front();
          check_field("debounced_state", want.debounced_state, out_data.debounced_state);
          check_field("rising_seen", want.rising_seen, out_data.rising_seen);
          check_field("falling_seen", want.falling_seen, out_data.falling_seen);
          check_field("change_seen", want.change_seen, out_data.change_seen);
          check_field("filter_out", want.filter_out, out_data.filter_out);
        end
      end
      if (in_valid && in_ready) debounce_step(in_data);
    end
    errors       <= err_n;
    pending      <= expected_results.size();
    results_seen <= res_n;
  end

endmodule

FILE: bench/iir_hysteresis_debouncer_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for iir_hysteresis_debouncer_top: clock, reset, sample and
// register stimulus, result sink and verdict. Depends on iird_pkg, iird_checker.
module iir_hysteresis_debouncer_top_tb;
  import iird_pkg::*;

  localparam int StallLimit   = 4000;
  localparam int HoldCycles   = 400;
  localparam int HoldAtResult = 700;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  in_t              in_data;
  logic             out_valid;
  logic             out_ready;
  out_t             out_data;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  int   errors;
  int   pending;
  int   results_seen;
  int   items_sent;
  int   settings_used;
  int   idle_cycles;
  int   gap_odds;
  logic calm;

  iir_hysteresis_debouncer_top uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  iird_checker scoreboard (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .errors      (errors),
    .pending     (pending),
    .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // no transfer on either channel for too long ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("iir_hysteresis_debouncer_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result sink: random stall bursts, one long hold-off mid run
  initial begin : result_sink
    int stall_odds;
    int mode_left;
    bit held;
    out_ready  = 1'b0;
    stall_odds = 0;
    mode_left  = 0;
    held       = 1'b0;
    do @(posedge clk); while (rst);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        case ($urandom_range(0, 3))
          0: stall_odds = 0;
          1: stall_odds = 2;
          2: stall_odds = 5;
          default: stall_odds = 9;
        endcase
        mode_left = 100;
      end
      mode_left--;
      if (!held && results_seen >= HoldAtResult) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!calm && stall_odds != 0 && $urandom_range(0, stall_odds) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  function automatic in_t make_item(op_t op, logic pin, logic [2:0] mask);
    in_t it;
    it.operation  = op;
    it.pin_level  = pin;
    it.clear_mask = mask;
    return it;
  endfunction

  task automatic send_item(in_t it);
    if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // leaves psel/penable high; the caller closes the access
  task automatic cfg_write(reg_idx_t idx, logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_filter(logic [WeightW-1:0] w, logic inv);
    cfg_write(REG_FILTER_WEIGHT, DataW'(w));
    cfg_write(REG_INVERT_INPUT, DataW'(inv));
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_used++;
  endtask

  // runs of one pin level with occasional glitches, mixed with status reads
  task automatic run_phase(int n, int run_max);
    logic lvl;
    logic pin;
    int   run_left;
    lvl      = 1'($urandom_range(0, 1));
    run_left = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 12) begin
        send_item(make_item(OP_STATUS, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7))));
      end else begin
        if (run_left == 0) begin
          lvl      = ~lvl;
          run_left = $urandom_range(1, run_max);
        end
        run_left--;
        pin = lvl;
        if ($urandom_range(0, 15) == 0) pin = ~lvl;
        send_item(make_item(OP_SAMPLE, pin, 3'($urandom_range(0, 7))));
      end
    end
    drain();
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    calm          = 1'b0;
    gap_odds      = 0;
    items_sent    = 0;
    settings_used = 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings; fields that the operation ignores are set
    send_item(make_item(OP_STATUS, 1'b1, 3'b111));
    send_item(make_item(OP_SAMPLE, 1'b1, 3'b111));
    send_item(make_item(OP_SAMPLE, 1'b0, 3'b000));
    send_item(make_item(OP_STATUS, 1'b0, 3'b000));
    drain();

    // full weight: each sample crosses a threshold
    set_filter(16'hFFFF, 1'b0);
    send_item(make_item(OP_SAMPLE, 1'b1, 3'b000));
    send_item(make_item(OP_STATUS, 1'b0, 3'b000));
    send_item(make_item(OP_SAMPLE, 1'b0, 3'b111));
    send_item(make_item(OP_STATUS, 1'b1, 3'b001));
    send_item(make_item(OP_STATUS, 1'b0, 3'b010));
    send_item(make_item(OP_STATUS, 1'b1, 3'b100));
    send_item(make_item(OP_STATUS, 1'b0, 3'b000));
    send_item(make_item(OP_SAMPLE, 1'b1, 3'b000));
    send_item(make_item(OP_STATUS, 1'b0, 3'b111));
    drain();

    // zero weight: level frozen
    set_filter(16'h0000, 1'b0);
    send_item(make_item(OP_SAMPLE, 1'b0, 3'b101));
    send_item(make_item(OP_SAMPLE, 1'b1, 3'b010));
    drain();

    // half weight, inverted: each sample moves the level about halfway to its target
    set_filter(16'h8000, 1'b1);
    send_item(make_item(OP_SAMPLE, 1'b0, 3'b000));
    send_item(make_item(OP_SAMPLE, 1'b1, 3'b000));
    send_item(make_item(OP_STATUS, 1'b0, 3'b000));
    send_item(make_item(OP_SAMPLE, 1'b1, 3'b000));
    send_item(make_item(OP_SAMPLE, 1'b0, 3'b000));
    send_item(make_item(OP_STATUS, 1'b1, 3'b111));
    drain();

    gap_odds = 4;
    set_filter(WeightReset, 1'b0);
    run_phase(200, 40);

    gap_odds = 0;
    set_filter(16'hFFFF, 1'b1);
    run_phase(150, 6);

    gap_odds = 6;
    set_filter(16'd1, 1'b0);
    run_phase(100, 20);

    gap_odds = 3;
    set_filter(16'd1200, 1'b1);
    run_phase(250, 120);

    gap_odds = 5;
    set_filter(WeightW'($urandom_range(1, 65535)), 1'($urandom_range(0, 1)));
    run_phase(200, 30);

    gap_odds = 2;
    set_filter(16'd45000, 1'b0);
    run_phase(200, 8);

    gap_odds = 4;
    set_filter(WeightW'($urandom_range(1, 65535)), 1'($urandom_range(0, 1)));
    run_phase(200, 30);

    // closing stretch with both sides at full rate
    calm <= 1'b1;
    set_filter(16'd9000, 1'b1);
    run_phase(230, 30);

    repeat (8) @(posedge clk);
    $display("Covered %0d sample/status transfers and %0d result transfers over %0d filter settings,",
             items_sent, results_seen, settings_used);
    $display("weights 0 to 65535, both polarities, random stalls and a %0d-cycle output hold.",
             HoldCycles);
    if (errors == 0 && pending == 0) begin
      $display("iir_hysteresis_debouncer_top verification clean");
    end else begin
      $display("iir_hysteresis_debouncer_top verification failed");
    end
    $finish;
  end

endmodule
